@@ rtl/core/dtf_pkg.sv @@
// Package for the decimal text to fixed-point converter.
// Holds character codes, command and status types and the fraction scale table.
// No dependencies.
`timescale 1ns / 1ps

package dtf_pkg;

  localparam int unsigned MAG_W    = 64;
  localparam int unsigned EXP_W    = 5;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned DIV_BITS = 8;
  localparam int unsigned DIV_CHUNKS = MAG_W / DIV_BITS;
  localparam int unsigned CHUNK_W  = $clog2(DIV_CHUNKS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_LOW_E = 8'h65;
  localparam logic [7:0] CHAR_UP_E  = 8'h45;

  localparam logic [MAG_W-1:0] MAG_CAP = 64'h8000_0000_0000_0000;
  localparam logic [MAG_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [FIDX_W-1:0] FIDX_LAST = 4'd9;
  localparam logic [4:0]        TEN       = 5'd10;

  typedef struct packed {
    logic digit;
    logic minus;
    logic dot;
    logic exp_mark;
  } char_class_t;

  typedef struct packed {
    logic int_digit;
    logic frac_digit;
    logic exp_digit;
    logic set_neg;
    logic set_exp_neg;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic exp_dec;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    char_class_t cls;
    logic        exp_zero;
    logic        exp_neg;
    logic        div_last;
    logic        out_free;
  } dp_status_t;

  // Weight of the next fraction digit in Q0.32, indexed by digits already taken.
  function automatic logic [31:0] frac_scale(input logic [FIDX_W-1:0] idx);
    logic [31:0] s;
    case (idx)
      4'd0:    s = 32'd429496730;
      4'd1:    s = 32'd42949673;
      4'd2:    s = 32'd4294967;
      4'd3:    s = 32'd429497;
      4'd4:    s = 32'd42950;
      4'd5:    s = 32'd4295;
      4'd6:    s = 32'd430;
      4'd7:    s = 32'd43;
      4'd8:    s = 32'd4;
      default: s = 32'd0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/dtf_ctrl.sv @@
// Controller of the decimal text to fixed-point converter.
// Tracks the parse phase and sequences the exponent scaling; uses dtf_pkg.
`timescale 1ns / 1ps

module dtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tlast,
  output logic                s_axis_tready,
  input  dtf_pkg::dp_status_t status_i,
  output dtf_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_START   = 3'd0;
  localparam logic [2:0] ST_INT     = 3'd1;
  localparam logic [2:0] ST_FRAC    = 3'd2;
  localparam logic [2:0] ST_EXPSIGN = 3'd3;
  localparam logic [2:0] ST_EXPDIG  = 3'd4;
  localparam logic [2:0] ST_STOP    = 3'd5;
  localparam logic [2:0] ST_SCALE   = 3'd6;
  localparam logic [2:0] ST_DIV     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ready;
  logic       acc;

  assign acc           = s_axis_tvalid & ready;
  assign s_axis_tready = ready;

  always_comb begin
    logic [2:0] nxt;
    state_d = state_q;
    cmd_o   = '0;
    ready   = 1'b0;
    nxt     = state_q;
    case (state_q)
      ST_START, ST_INT: begin
        ready = 1'b1;
        if (status_i.cls.digit) begin
          cmd_o.int_digit = acc;
          nxt = ST_INT;
        end else if ((state_q == ST_START) && status_i.cls.minus) begin
          cmd_o.set_neg = acc;
          nxt = ST_INT;
        end else if (status_i.cls.dot) begin
          nxt = ST_FRAC;
        end else if (status_i.cls.exp_mark) begin
          nxt = ST_EXPSIGN;
        end else begin
          nxt = ST_STOP;
        end
      end
      ST_FRAC: begin
        ready = 1'b1;
        if (status_i.cls.digit) begin
          cmd_o.frac_digit = acc;
        end else if (status_i.cls.exp_mark) begin
          nxt = ST_EXPSIGN;
        end else begin
          nxt = ST_STOP;
        end
      end
      ST_EXPSIGN, ST_EXPDIG: begin
        ready = 1'b1;
        if (status_i.cls.digit) begin
          cmd_o.exp_digit = acc;
          nxt = ST_EXPDIG;
        end else if ((state_q == ST_EXPSIGN) && status_i.cls.minus) begin
          cmd_o.set_exp_neg = acc;
          nxt = ST_EXPDIG;
        end else begin
          nxt = ST_STOP;
        end
      end
      ST_STOP: begin
        ready = 1'b1;
      end
      ST_SCALE: begin
        if (status_i.exp_zero) begin
          if (status_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d = ST_START;
          end
        end else if (status_i.exp_neg) begin
          cmd_o.div_load = 1'b1;
          state_d = ST_DIV;
        end else begin
          cmd_o.mul_step = 1'b1;
          cmd_o.exp_dec  = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.exp_dec = 1'b1;
          state_d = ST_SCALE;
        end
      end
      default: begin
        state_d = ST_START;
      end
    endcase
    if (acc) begin
      state_d = s_axis_tlast ? ST_SCALE : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_START;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/dtf_datapath.sv @@
// Datapath of the decimal text to fixed-point converter.
// Accumulators, exponent scaling by ten, divide-by-ten unit and output register; uses dtf_pkg.
`timescale 1ns / 1ps

module dtf_datapath #(
  parameter int unsigned FRAC_BITS    = 32,
  parameter int unsigned MAX_EXPONENT = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          char_i,
  input  dtf_pkg::dp_cmd_t    cmd_i,
  output dtf_pkg::dp_status_t status_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [63:0]         fixed_value_o,
  output logic                fixed_saturated_o,
  output logic [63:0]         int_value_o,
  output logic                int_saturated_o
);

  localparam int unsigned SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int unsigned SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 1;
  localparam logic [63:0] RND = 64'd1 << (SHR - 1);

  logic [63:0]                     mant_q, mant_d;
  logic [63:0]                     int_q, int_d;
  logic [dtf_pkg::FIDX_W-1:0]      fidx_q, fidx_d;
  logic                            neg_q, neg_d;
  logic                            exp_neg_q, exp_neg_d;
  logic [dtf_pkg::EXP_W-1:0]       exp_q, exp_d;
  logic [1:0]                      marks_q, marks_d;
  logic [3:0]                      rem_q, rem_d;
  logic [dtf_pkg::CHUNK_W-1:0]     chunk_q, chunk_d;
  logic                            out_valid_q, out_valid_d;
  logic [63:0]                     fixed_q, fixed_d;
  logic [63:0]                     ival_q, ival_d;
  logic [1:0]                      sat_q, sat_d;

  logic [3:0]  digit;
  logic [67:0] m_add, m_sum, i_sum;
  logic        m_over, i_over;
  logic [35:0] prod;
  logic [63:0] part;
  logic [64:0] f_sum;
  logic        f_over;
  logic [8:0]  e_sum;
  logic [63:0] div_w;
  logic [4:0]  div_r;

  assign digit = char_i[3:0];

  assign status_o.cls.digit    = (char_i >= dtf_pkg::CHAR_ZERO) && (char_i <= dtf_pkg::CHAR_NINE);
  assign status_o.cls.minus    = char_i == dtf_pkg::CHAR_MINUS;
  assign status_o.cls.dot      = char_i == dtf_pkg::CHAR_DOT;
  assign status_o.cls.exp_mark = (char_i == dtf_pkg::CHAR_LOW_E) ||
                                 (char_i == dtf_pkg::CHAR_UP_E);
  assign status_o.exp_zero     = exp_q == '0;
  assign status_o.exp_neg      = exp_neg_q;
  assign status_o.div_last     = chunk_q == dtf_pkg::CHUNK_W'(dtf_pkg::DIV_CHUNKS - 1);
  assign status_o.out_free     = !out_valid_q || out_ready_i;

  assign m_add  = cmd_i.int_digit ? (68'(digit) << FRAC_BITS) : '0;
  assign m_sum  = 68'({mant_q, 3'b000}) + 68'({mant_q, 1'b0}) + m_add;
  assign m_over = m_sum > 68'(dtf_pkg::MAG_CAP);
  assign i_sum  = 68'({int_q, 3'b000}) + 68'({int_q, 1'b0}) + 68'(digit);
  assign i_over = i_sum > 68'(dtf_pkg::MAG_CAP);

  assign prod = 36'(digit) * 36'(dtf_pkg::frac_scale(fidx_q));

  always_comb begin
    if (FRAC_BITS >= 32) begin
      part = 64'(prod) << SHL;
    end else begin
      part = (64'(prod) + RND) >> SHR;
    end
  end

  assign f_sum  = {1'b0, mant_q} + {1'b0, part};
  assign f_over = f_sum > 65'(dtf_pkg::MAG_CAP);
  assign e_sum  = 9'({exp_q, 3'b000}) + 9'({exp_q, 1'b0}) + 9'(digit);

  // Restoring long division by ten, DIV_BITS quotient bits per division step.
  always_comb begin
    div_w = mant_q;
    div_r = {1'b0, rem_q};
    for (int k = 0; k < int'(dtf_pkg::DIV_BITS); k++) begin
      div_r = {div_r[3:0], div_w[63]};
      if (div_r >= dtf_pkg::TEN) begin
        div_r = div_r - dtf_pkg::TEN;
        div_w = {div_w[62:0], 1'b1};
      end else begin
        div_w = {div_w[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    mant_d      = mant_q;
    int_d       = int_q;
    fidx_d      = fidx_q;
    neg_d       = neg_q;
    exp_neg_d   = exp_neg_q;
    exp_d       = exp_q;
    marks_d     = marks_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fixed_d     = fixed_q;
    ival_d      = ival_q;
    sat_d       = sat_q;

    if (cmd_i.int_digit || cmd_i.mul_step) begin
      mant_d = m_over ? dtf_pkg::MAG_CAP : m_sum[63:0];
      if (m_over) begin
        marks_d[0] = 1'b1;
      end
    end
    if (cmd_i.int_digit) begin
      int_d = i_over ? dtf_pkg::MAG_CAP : i_sum[63:0];
      if (i_over) begin
        marks_d[1] = 1'b1;
      end
    end
    if (cmd_i.frac_digit) begin
      mant_d = f_over ? dtf_pkg::MAG_CAP : f_sum[63:0];
      if (f_over) begin
        marks_d[0] = 1'b1;
      end
      if (fidx_q != dtf_pkg::FIDX_LAST) begin
        fidx_d = fidx_q + 1'b1;
      end
    end
    if (cmd_i.exp_digit) begin
      exp_d = (e_sum > 9'(MAX_EXPONENT)) ? dtf_pkg::EXP_W'(MAX_EXPONENT) : e_sum[4:0];
    end
    if (cmd_i.set_neg) begin
      neg_d = 1'b1;
    end
    if (cmd_i.set_exp_neg) begin
      exp_neg_d = 1'b1;
    end
    if (cmd_i.div_load) begin
      mant_d  = mant_q + 64'd5;
      rem_d   = '0;
      chunk_d = '0;
    end
    if (cmd_i.div_step) begin
      mant_d  = div_w;
      rem_d   = div_r[3:0];
      chunk_d = chunk_q + 1'b1;
    end
    if (cmd_i.exp_dec) begin
      exp_d = exp_q - 1'b1;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      if (neg_q) begin
        fixed_d  = marks_q[0] ? dtf_pkg::MAG_CAP : (64'd0 - mant_q);
        sat_d[0] = marks_q[0];
        ival_d   = marks_q[1] ? dtf_pkg::MAG_CAP : (64'd0 - int_q);
        sat_d[1] = marks_q[1];
      end else begin
        fixed_d  = (marks_q[0] || mant_q[63]) ? dtf_pkg::POS_MAX : mant_q;
        sat_d[0] = marks_q[0] || mant_q[63];
        ival_d   = (marks_q[1] || int_q[63]) ? dtf_pkg::POS_MAX : int_q;
        sat_d[1] = marks_q[1] || int_q[63];
      end
      mant_d    = '0;
      int_d     = '0;
      fidx_d    = '0;
      neg_d     = 1'b0;
      exp_neg_d = 1'b0;
      exp_d     = '0;
      marks_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mant_q      <= '0;
      int_q       <= '0;
      fidx_q      <= '0;
      neg_q       <= 1'b0;
      exp_neg_q   <= 1'b0;
      exp_q       <= '0;
      marks_q     <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mant_q      <= mant_d;
      int_q       <= int_d;
      fidx_q      <= fidx_d;
      neg_q       <= neg_d;
      exp_neg_q   <= exp_neg_d;
      exp_q       <= exp_d;
      marks_q     <= marks_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    fixed_q <= fixed_d;
    ival_q  <= ival_d;
    sat_q   <= sat_d;
  end

  assign out_valid_o       = out_valid_q;
  assign fixed_value_o     = fixed_q;
  assign fixed_saturated_o = sat_q[0];
  assign int_value_o       = ival_q;
  assign int_saturated_o   = sat_q[1];

endmodule

@@ rtl/core/decimal_text_to_fixed_unit.sv @@
// Characters without tlast are taken one per cycle. After the last character of a token the
// result is multiplied by ten E times for an exponent E >= 0, or divided by ten E times
// through the divide-by-ten unit for a negative exponent, before it is registered.
// The input stalls during that scaling and until the output register is free; the next token
// is taken once the result is registered, even while the previous result still waits.
// Reset is asynchronous active low and clears the parse state and the output valid flag.
`timescale 1ns / 1ps

module decimal_text_to_fixed_unit #(
  parameter int unsigned FRAC_BITS    = 32,
  parameter int unsigned MAX_EXPONENT = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_char
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] fixed_value, [127:64] int_value
  output logic [1:0]   m_axis_tuser    // [0] fixed_saturated, [1] int_saturated
);

  dtf_pkg::dp_cmd_t    cmd;
  dtf_pkg::dp_status_t status;
  logic [63:0]         fixed_value;
  logic [63:0]         int_value;
  logic                fixed_saturated;
  logic                int_saturated;

  dtf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  dtf_datapath #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .char_i            (s_axis_tdata),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .fixed_value_o     (fixed_value),
    .fixed_saturated_o (fixed_saturated),
    .int_value_o       (int_value),
    .int_saturated_o   (int_saturated)
  );

  assign m_axis_tdata = {int_value, fixed_value};
  assign m_axis_tuser = {int_saturated, fixed_saturated};

endmodule

@@ rtl/core/dtf_checker.sv @@
// Port-level checks for the decimal text to fixed-point converter.
// Bound to decimal_text_to_fixed_unit; no other dependencies.
`timescale 1ns / 1ps

module dtf_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_fixed_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF) ||
      (m_axis_tdata[63:0] == 64'h8000_0000_0000_0000))
    else $error("saturated fixed value is not a clamp value");

  a_int_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[127:64] == 64'h7FFF_FFFF_FFFF_FFFF) ||
      (m_axis_tdata[127:64] == 64'h8000_0000_0000_0000))
    else $error("saturated integer value is not a clamp value");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken while a token was being scaled");

endmodule

bind decimal_text_to_fixed_unit dtf_checker u_dtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ dv/decimal_text_to_fixed_checker.sv @@
// Checker for the decimal text to fixed-point converter: watches both stream channels,
// predicts each token's result from the accepted characters and compares every output beat.
// Depends on dtf_pkg for the character codes and the clamp values.
`timescale 1ns / 1ps

module decimal_text_to_fixed_checker
  import dtf_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 32,
  parameter int unsigned MAX_EXPONENT = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_char
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,   // [63:0] fixed_value, [127:64] int_value
  input  logic [1:0]   m_axis_tuser,   // [0] fixed_saturated, [1] int_saturated
  output int           fail_count_o,
  output int           pending_o,
  output int           checked_o,
  output int           fixed_clamps_o,
  output int           int_clamps_o
);

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_WHOLE,
    SCAN_FRAC,
    SCAN_EXP_SIGN,
    SCAN_EXP_DIGITS,
    SCAN_HALTED
  } scan_phase_e;

  typedef struct packed {
    logic [63:0] fixed_value;
    logic        fixed_sat;
    logic [63:0] int_value;
    logic        int_sat;
  } conversion_t;

  localparam logic [31:0] TENTH_WEIGHT = 32'h1999_999A;

  scan_phase_e scan_phase;
  logic [63:0] mag_acc;
  logic [31:0] frac_weight;
  logic        neg_value;
  logic        neg_exp;
  logic [4:0]  exp_digits;
  logic [63:0] whole_acc;
  logic        clamp_fixed;
  logic        clamp_whole;
  conversion_t pending_conversions[$];

  function automatic void clear_token();
    scan_phase  = SCAN_LEAD;
    mag_acc     = '0;
    frac_weight = TENTH_WEIGHT;
    neg_value   = 1'b0;
    neg_exp     = 1'b0;
    exp_digits  = '0;
    whole_acc   = '0;
    clamp_fixed = 1'b0;
    clamp_whole = 1'b0;
  endfunction

  function automatic logic [63:0] mul10_add_capped(input logic [63:0] a, input logic [63:0] b,
                                                   output logic hit);
    hit = a > (MAG_CAP - b) / 64'd10;
    return hit ? MAG_CAP : a * 64'd10 + b;
  endfunction

  function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b,
                                             output logic hit);
    hit = b > MAG_CAP - a;
    return hit ? MAG_CAP : a + b;
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic [63:0] d;
    logic [63:0] part;
    logic        is_digit;
    logic        is_exp;
    logic        hit;
    int unsigned e;
    d        = {60'd0, 4'(c - CHAR_ZERO)};
    is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
    is_exp   = c == CHAR_LOW_E || c == CHAR_UP_E;
    case (scan_phase)
      SCAN_LEAD, SCAN_WHOLE: begin
        if (is_digit) begin
          mag_acc     = mul10_add_capped(mag_acc, d << FRAC_BITS, hit);
          clamp_fixed |= hit;
          whole_acc   = mul10_add_capped(whole_acc, d, hit);
          clamp_whole |= hit;
          scan_phase  = SCAN_WHOLE;
        end else if (scan_phase == SCAN_LEAD && c == CHAR_MINUS) begin
          neg_value  = 1'b1;
          scan_phase = SCAN_WHOLE;
        end else if (c == CHAR_DOT) begin
          scan_phase = SCAN_FRAC;
        end else begin
          scan_phase = is_exp ? SCAN_EXP_SIGN : SCAN_HALTED;
        end
      end
      SCAN_FRAC: begin
        if (is_digit) begin
          part = d * frac_weight;
          if (FRAC_BITS >= 32) begin
            part = part << (FRAC_BITS - 32);
          end else begin
            part = (part + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
          end
          mag_acc     = add_capped(mag_acc, part, hit);
          clamp_fixed |= hit;
          frac_weight = 32'((64'(frac_weight) + 64'd5) / 64'd10);
        end else begin
          scan_phase = is_exp ? SCAN_EXP_SIGN : SCAN_HALTED;
        end
      end
      SCAN_EXP_SIGN, SCAN_EXP_DIGITS: begin
        if (is_digit) begin
          e          = exp_digits * 10 + d[3:0];
          exp_digits = (e > MAX_EXPONENT) ? 5'(MAX_EXPONENT) : 5'(e);
          scan_phase = SCAN_EXP_DIGITS;
        end else if (scan_phase == SCAN_EXP_SIGN && c == CHAR_MINUS) begin
          neg_exp    = 1'b1;
          scan_phase = SCAN_EXP_DIGITS;
        end else begin
          scan_phase = SCAN_HALTED;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_sign(input logic [63:0] mag, input logic neg, input logic marked,
                                     output logic [63:0] value, output logic flag);
    if (neg) begin
      flag  = marked;
      value = marked ? MAG_CAP : 64'd0 - mag;
    end else if (marked || mag > POS_MAX) begin
      flag  = 1'b1;
      value = POS_MAX;
    end else begin
      flag  = 1'b0;
      value = mag;
    end
  endfunction

  function automatic conversion_t close_token();
    conversion_t r;
    logic [63:0] mag;
    logic        hit;
    mag = mag_acc;
    for (int i = 0; i < exp_digits && i < 31; i++) begin
      if (neg_exp) begin
        mag = (mag + 64'd5) / 64'd10;
      end else begin
        mag         = mul10_add_capped(mag, 64'd0, hit);
        clamp_fixed |= hit;
      end
    end
    apply_sign(mag, neg_value, clamp_fixed, r.fixed_value, r.fixed_sat);
    apply_sign(whole_acc, neg_value, clamp_whole, r.int_value, r.int_sat);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, $signed(want),
               $signed(got));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    conversion_t want;
    conversion_t got;
    if (!rst_ni) begin
      clear_token();
      pending_conversions.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      checked_o      = 0;
      fixed_clamps_o = 0;
      int_clamps_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.fixed_value = m_axis_tdata[63:0];
        got.int_value   = m_axis_tdata[127:64];
        got.fixed_sat   = m_axis_tuser[0];
        got.int_sat     = m_axis_tuser[1];
        if (pending_conversions.size() == 0) begin
          fail_count_o++;
          $display("%0t: output beat with no result expected, fixed %0d, integer %0d", $time,
                   $signed(got.fixed_value), $signed(got.int_value));
        end else begin
          want = pending_conversions.pop_front();
          checked_o++;
          compare_field("fixed_value", want.fixed_value, got.fixed_value);
          compare_field("fixed_saturated", 64'(want.fixed_sat), 64'(got.fixed_sat));
          compare_field("int_value", want.int_value, got.int_value);
          compare_field("int_saturated", 64'(want.int_sat), 64'(got.int_sat));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_char(s_axis_tdata);
        if (s_axis_tlast) begin
          want = close_token();
          pending_conversions.push_back(want);
          if (want.fixed_sat) fixed_clamps_o++;
          if (want.int_sat) int_clamps_o++;
          clear_token();
        end
      end
      pending_o = pending_conversions.size();
    end
  end

endmodule

@@ dv/decimal_text_to_fixed_unit_tb.sv @@
// Testbench top for the decimal text to fixed-point converter: drives number tokens one
// character per beat with bursty input and a stalling output, and gives the verdict.
// Depends on dtf_pkg, decimal_text_to_fixed_unit and decimal_text_to_fixed_checker.
`timescale 1ns / 1ps

module decimal_text_to_fixed_unit_tb;
  import dtf_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 250;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int fail_count;
  int pending;
  int checked;
  int fixed_clamps;
  int int_clamps;

  int         chars_sent;
  int         tokens_sent;
  int         burst_left;
  int         idle_cycles;
  int         random_target;
  logic       hold_req;
  logic       hold_done;
  logic       paused;
  logic [7:0] token_text[$];

  decimal_text_to_fixed_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  decimal_text_to_fixed_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .fixed_clamps_o (fixed_clamps),
    .int_clamps_o   (int_clamps)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic push_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_token();
    for (int k = 0; k < token_text.size(); k++) begin
      push_char(token_text[k], k == token_text.size() - 1);
    end
    tokens_sent++;
  endtask

  task automatic send_text(input string s);
    token_text.delete();
    for (int k = 0; k < s.len(); k++) token_text.push_back(s[k]);
    send_token();
  endtask

  task automatic push_digits(input int count);
    for (int k = 0; k < count; k++) token_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Mostly well-formed numbers with random content; some tokens are pure noise and some
  // have a stray byte dropped in somewhere.
  task automatic build_token();
    int kind;
    int pos;
    kind = $urandom_range(0, 15);
    token_text.delete();
    if (kind < 2) begin
      repeat ($urandom_range(1, 6)) token_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) token_text.push_back(CHAR_MINUS);
      push_digits(($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 22));
      if ($urandom_range(0, 1) == 1) begin
        token_text.push_back(CHAR_DOT);
        push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 4));
      end
      if ($urandom_range(0, 2) == 0) begin
        token_text.push_back(($urandom_range(0, 1) == 1) ? CHAR_LOW_E : CHAR_UP_E);
        if ($urandom_range(0, 1) == 1) token_text.push_back(CHAR_MINUS);
        push_digits($urandom_range(0, 3));
      end
      if (kind < 4) begin
        pos = $urandom_range(0, token_text.size());
        token_text.insert(pos, 8'($urandom_range(0, 255)));
      end
      if (token_text.size() == 0) push_digits(1);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    burst_left = 0;
  endtask

  // Output side: stall patterns of random length, with one long hold-off on request.
  initial begin
    int mode;
    int phase_cnt;
    m_axis_tready = 1'b0;
    hold_done     = 1'b0;
    phase_cnt     = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(10, 120)) begin
          @(negedge clk_i);
          phase_cnt++;
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 3) != 0;
            2:       m_axis_tready <= $urandom_range(0, 3) == 0;
            default: m_axis_tready <= (phase_cnt % 3) != 0;
          endcase
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    hold_req      = 1'b0;
    paused        = 1'b0;
    chars_sent    = 0;
    tokens_sent   = 0;
    burst_left    = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text("-");
    send_text(".");
    send_text("e-");
    send_text("-0");
    for (int b = 0; b < 2; b++) begin
      token_text.delete();
      token_text.push_back(b ? 8'hFF : 8'h00);
      send_token();
    end
    send_text("1.5E3");
    send_text("1e99");
    send_text("-5e9");
    send_text("9999999999e-9");
    drain_results();

    random_target = chars_sent + RANDOM_ITEMS;
    while (chars_sent < random_target) begin
      if (!hold_req && chars_sent > random_target - 800) hold_req = 1'b1;
      if (!paused && chars_sent > random_target - 450) begin
        drain_results();
        paused = 1'b1;
      end
      build_token();
      send_token();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d characters in %0d tokens, with bursty input, a long output hold-off",
             chars_sent, tokens_sent);
    $display("and a full drain; %0d results checked, %0d fixed and %0d integer clamps.",
             checked, fixed_clamps, int_clamps);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
